// ===== rtl/dpsc_pkg.sv =====
`default_nettype none

package dpsc_pkg;

  // Width of the millisecond counters
  localparam int TIME_BITS = 16;
  // Largest series count that is taken as a preset
  localparam int MAX_PRESET = 10;

  localparam int CFG_BITS   = 16;
  localparam int COUNT_BITS = 4;
  localparam int CMP_BITS   = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  localparam logic [TIME_BITS-1:0]  TIME_MAX  = {TIME_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] PRESET_MAX = COUNT_BITS'(MAX_PRESET);

  // Register indexes
  localparam logic [1:0] REG_MIN_PULSE = 2'd0;
  localparam logic [1:0] REG_MAX_PULSE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;
  localparam logic [1:0] REG_DEBOUNCE  = 2'd3;

  localparam logic [CFG_BITS-1:0] MIN_PULSE_RST = 16'd100;
  localparam logic [CFG_BITS-1:0] MAX_PULSE_RST = 16'd200;
  localparam logic [CFG_BITS-1:0] TIMEOUT_RST   = 16'd400;
  localparam logic [CFG_BITS-1:0] DEBOUNCE_RST  = 16'd5;

  // Transaction kinds
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef struct packed {
    logic [CFG_BITS-1:0] min_pulse;
    logic [CFG_BITS-1:0] max_pulse;
    logic [CFG_BITS-1:0] timeout;
    logic [CFG_BITS-1:0] debounce;
  } cfg_t;

  typedef struct packed {
    logic                  last_raw;
    logic [TIME_BITS-1:0]  since_change;
    logic                  stable_level;
    logic                  level_valid;
    logic                  pulse_low;
    logic [TIME_BITS-1:0]  pulse_length;
    logic                  series_active;
    logic [COUNT_BITS-1:0] series_count;
    logic [TIME_BITS-1:0]  gap_length;
    logic [COUNT_BITS-1:0] confirmed;
  } state_t;

  typedef struct packed {
    logic                  level_stable;
    logic                  series_open;
    logic                  preset_updated;
    logic [COUNT_BITS-1:0] preset;
  } result_t;

  localparam state_t STATE_RST = '{
    last_raw:      1'b1,
    since_change:  TIME_MAX,
    stable_level:  1'b1,
    level_valid:   1'b0,
    pulse_low:     1'b0,
    pulse_length:  '0,
    series_active: 1'b0,
    series_count:  '0,
    gap_length:    '0,
    confirmed:     '0
  };

  function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
    return (v == TIME_MAX) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dpsc_step.sv =====
`default_nettype none

// One tick (or clear) of the detector: next state and result.
module dpsc_step (
  input  wire  dpsc_pkg::cfg_t   cfg,
  input  wire  dpsc_pkg::state_t st,
  input  wire                    func,
  input  wire                    raw_level,
  output dpsc_pkg::state_t       st_nxt,
  output dpsc_pkg::result_t      res
);

  logic updated;
  logic in_window;
  logic [dpsc_pkg::CMP_BITS-1:0] len_ext;

  always_comb begin
    st_nxt    = st;
    updated   = 1'b0;
    len_ext   = '0;
    in_window = 1'b0;
    if (func == dpsc_pkg::FUNC_CLEAR) begin
      st_nxt.series_active = 1'b0;
      st_nxt.series_count  = '0;
      st_nxt.confirmed     = '0;
      st_nxt.pulse_low     = 1'b0;
      st_nxt.level_valid   = 1'b0;
      st_nxt.pulse_length  = '0;
      st_nxt.gap_length    = '0;
    end else begin
      if (raw_level != st.last_raw) begin
        st_nxt.last_raw     = raw_level;
        st_nxt.since_change = '0;
      end else begin
        st_nxt.since_change = dpsc_pkg::sat_inc(st.since_change);
      end
      if (st.pulse_low) begin
        st_nxt.pulse_length = dpsc_pkg::sat_inc(st.pulse_length);
      end
      if (st.series_active) begin
        st_nxt.gap_length = dpsc_pkg::sat_inc(st.gap_length);
      end

      len_ext   = dpsc_pkg::CMP_BITS'(st_nxt.pulse_length);
      in_window = (len_ext >= dpsc_pkg::CMP_BITS'(cfg.min_pulse)) &&
                  (len_ext <= dpsc_pkg::CMP_BITS'(cfg.max_pulse));

      if (dpsc_pkg::CMP_BITS'(st_nxt.since_change) >= dpsc_pkg::CMP_BITS'(cfg.debounce)) begin
        if (!st.level_valid) begin
          // first stable level is captured, not an edge
          st_nxt.stable_level = st_nxt.last_raw;
          st_nxt.level_valid  = 1'b1;
        end else if (st_nxt.last_raw != st.stable_level) begin
          st_nxt.stable_level = st_nxt.last_raw;
          if (!st_nxt.last_raw) begin
            st_nxt.pulse_low    = 1'b1;
            st_nxt.pulse_length = '0;
          end else if (st.pulse_low) begin
            if (in_window) begin
              if (!st.series_active) begin
                st_nxt.series_active = 1'b1;
                st_nxt.series_count  = dpsc_pkg::COUNT_BITS'(1);
              end else if (st.series_count < dpsc_pkg::COUNT_MAX) begin
                st_nxt.series_count = st.series_count + 1'b1;
              end
              st_nxt.gap_length = '0;
            end else begin
              st_nxt.series_active = 1'b0;
              st_nxt.series_count  = '0;
            end
            st_nxt.pulse_low = 1'b0;
          end
        end
      end

      if (st_nxt.series_active && !st_nxt.pulse_low &&
          (dpsc_pkg::CMP_BITS'(st_nxt.gap_length) > dpsc_pkg::CMP_BITS'(cfg.timeout))) begin
        if ((st_nxt.series_count != '0) && (st_nxt.series_count <= dpsc_pkg::PRESET_MAX)) begin
          st_nxt.confirmed = st_nxt.series_count;
          updated          = 1'b1;
        end
        st_nxt.series_active = 1'b0;
        st_nxt.series_count  = '0;
      end
    end

    res.preset         = st_nxt.confirmed;
    res.preset_updated = updated;
    res.series_open    = st_nxt.series_active;
    res.level_stable   = st_nxt.stable_level;
  end

endmodule

`default_nettype wire

// ===== rtl/debounced_pulse_series_counter_core.sv =====
`default_nettype none

// Debounced pulse-series counter. Feed one transaction per millisecond tick
// carrying the raw active-low pin level (tuser = 0), or a clear command
// (tuser = 1); every input transaction yields exactly one result transaction.
// The level is debounced over debounce_ms ticks, the first stable level after
// reset or clear is only captured, and each low pulse whose length lies in
// [min_pulse_ms, max_pulse_ms] adds to the series count, while any other pulse
// drops the series. Once more than series_timeout_ms ticks pass after the last
// good pulse, a count of 1 to MAX_PRESET becomes the confirmed preset and
// preset_updated is set for that one result. Rate: one transaction per clock
// unless the consumer stalls; the whole tick update is a single combinational
// pass into the state and result registers, and the result register accepts a
// new transaction in the same cycle its old one is taken. The user must write
// registers over APB only while idle; the block itself does not enforce it.
module debounced_pulse_series_counter_core (
  input  wire         clk,
  input  wire         rst_n,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,    // [0] raw_level, [7:1] zero
  input  wire  [0:0]  in_tuser,    // [0] func: 0 tick, 1 clear
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,   // [3:0] preset, [4] preset_updated,
                                   // [5] series open, [6] level_stable, [7] zero
  // configuration
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  dpsc_pkg::cfg_t    cfg_r;
  dpsc_pkg::state_t  st_r;
  dpsc_pkg::state_t  st_nxt;
  dpsc_pkg::result_t res_nxt;
  dpsc_pkg::result_t res_r;
  logic              out_valid_r;
  logic              in_accept;
  logic              cfg_write;
  logic [1:0]        cfg_index;

  // --- configuration: index from word address, upper half of pwdata ignored
  assign cfg_pready = 1'b1;
  assign cfg_index  = cfg_paddr[3:2];
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_pulse <= dpsc_pkg::MIN_PULSE_RST;
      cfg_r.max_pulse <= dpsc_pkg::MAX_PULSE_RST;
      cfg_r.timeout   <= dpsc_pkg::TIMEOUT_RST;
      cfg_r.debounce  <= dpsc_pkg::DEBOUNCE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        dpsc_pkg::REG_MIN_PULSE: cfg_r.min_pulse <= cfg_pwdata[15:0];
        dpsc_pkg::REG_MAX_PULSE: cfg_r.max_pulse <= cfg_pwdata[15:0];
        dpsc_pkg::REG_TIMEOUT:   cfg_r.timeout   <= cfg_pwdata[15:0];
        dpsc_pkg::REG_DEBOUNCE:  cfg_r.debounce  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      dpsc_pkg::REG_MIN_PULSE: cfg_prdata = {16'd0, cfg_r.min_pulse};
      dpsc_pkg::REG_MAX_PULSE: cfg_prdata = {16'd0, cfg_r.max_pulse};
      dpsc_pkg::REG_TIMEOUT:   cfg_prdata = {16'd0, cfg_r.timeout};
      dpsc_pkg::REG_DEBOUNCE:  cfg_prdata = {16'd0, cfg_r.debounce};
      default:                 cfg_prdata = '0;
    endcase
  end

  // --- stream handshake: a held result never blocks the next transaction
  // when the consumer takes it in the same cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  dpsc_step u_step (
    .cfg       (cfg_r),
    .st        (st_r),
    .func      (in_tuser[0]),
    .raw_level (in_tdata[0]),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  // detector state advances only on an accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dpsc_pkg::STATE_RST;
    end else if (in_accept) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.level_stable, res_r.series_open,
                       res_r.preset_updated, res_r.preset};

`ifndef SYNTHESIS
  a_update_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.preset_updated) |->
      ((res_r.preset != '0) && (res_r.preset <= dpsc_pkg::PRESET_MAX)))
    else $error("preset reported outside its range");

  a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.series_active |-> (st_r.series_count == '0))
    else $error("series count held without an open series");

  a_clear_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_tuser[0] == dpsc_pkg::FUNC_CLEAR)) |=>
      (!st_r.level_valid && (st_r.confirmed == '0) && !st_r.series_active))
    else $error("clear left detector state behind");

  a_result_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_tready))
    else $error("result dropped before being taken");
`endif

endmodule

`default_nettype wire
